/* sv/mva_pkg.sv */
// Shared types, constants and helpers for the masked vector integer ALU.
// No dependencies; every other file refers to it by scoped names.
package mva_pkg;

	localparam int LANES     = 4;   // active lanes, 2 to MAX_LANES
	localparam int LANE_BITS = 32;  // lane width
	localparam int MAX_LANES = 4;   // lanes carried by the channel
	localparam int FUNC_W    = 5;
	localparam int MASK_W    = 4;
	localparam int SHAMT_W   = 5;   // shift count bits taken from b
	localparam int CNT_W     = $clog2(LANE_BITS);

	localparam logic [MASK_W-1:0] LANE_MASK = MASK_W'((1 << LANES) - 1);

	typedef logic [LANE_BITS-1:0] lane_t;

	typedef enum logic [FUNC_W-1:0] {
		F_ADD, F_SUB, F_MUL, F_DIV, F_ABS, F_SRA, F_AND,
		F_GT, F_LT, F_EQ, F_SET, F_MOVE, F_HADD, F_ILV,
		F_REDUCE, F_COUNT, F_FIRST, F_NOT, F_OR, F_MAND
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE, ST_DIV, ST_COMMIT
	} state_t;

	typedef struct packed {
		func_t func;
		logic  div_load;
		logic  div_step;
	} lane_ctl_t;

	typedef struct packed {
		lane_t val;
		logic  mbit;
	} lane_out_t;

	function automatic lane_t lane_abs(lane_t v);
		lane_abs = v[LANE_BITS-1] ? lane_t'(-v) : v;
	endfunction

endpackage

/* sv/mva_in_if.sv */
// Input channel of the vector ALU: opcode, two operand vectors, two masks.
// Depends on mva_pkg for the lane, opcode and mask widths.
interface mva_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [mva_pkg::FUNC_W-1:0]           func;
	logic signed [mva_pkg::LANE_BITS-1:0] lane_a0;
	logic signed [mva_pkg::LANE_BITS-1:0] lane_a1;
	logic signed [mva_pkg::LANE_BITS-1:0] lane_a2;
	logic signed [mva_pkg::LANE_BITS-1:0] lane_a3;
	logic signed [mva_pkg::LANE_BITS-1:0] lane_b0;
	logic signed [mva_pkg::LANE_BITS-1:0] lane_b1;
	logic signed [mva_pkg::LANE_BITS-1:0] lane_b2;
	logic signed [mva_pkg::LANE_BITS-1:0] lane_b3;
	logic [mva_pkg::MASK_W-1:0]           exec_mask;
	logic [mva_pkg::MASK_W-1:0]           other_mask;

	modport source (
		output valid, func, lane_a0, lane_a1, lane_a2, lane_a3,
		output lane_b0, lane_b1, lane_b2, lane_b3, exec_mask, other_mask,
		input  ready
	);
	modport sink (
		input  valid, func, lane_a0, lane_a1, lane_a2, lane_a3,
		input  lane_b0, lane_b1, lane_b2, lane_b3, exec_mask, other_mask,
		output ready
	);
endinterface

/* sv/mva_out_if.sv */
// Output channel of the vector ALU: result vector, result mask, scalar.
// Depends on mva_pkg for the lane and mask widths.
interface mva_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [mva_pkg::LANE_BITS-1:0] res_0;
	logic signed [mva_pkg::LANE_BITS-1:0] res_1;
	logic signed [mva_pkg::LANE_BITS-1:0] res_2;
	logic signed [mva_pkg::LANE_BITS-1:0] res_3;
	logic [mva_pkg::MASK_W-1:0]           mask_out;
	logic signed [mva_pkg::LANE_BITS-1:0] scalar_out;

	modport source (
		output valid, res_0, res_1, res_2, res_3, mask_out, scalar_out,
		input  ready
	);
	modport sink (
		input  valid, res_0, res_1, res_2, res_3, mask_out, scalar_out,
		output ready
	);
endinterface

/* sv/masked_vector_integer_alu.sv */
// Top level of the four-lane masked integer vector ALU.
// Depends on mva_pkg, mva_in_if, mva_out_if, mva_lane and mva_merge.
//
//  channel | modport     | transaction
//  --------+-------------+--------------------------------------------------
//  req     | sink        | func, lane_a0..3, lane_b0..3, exec_mask, other_mask
//  rsp     | source      | res_0..3, mask_out, scalar_out (state after the op)
//
//  Sequence: accept, then commit; no new op is accepted before the commit;
//  a div op first runs the one-bit-per-cycle restoring divider in each lane.
//  Reset: arst_n clears the result vector, result mask and control state.
//  Stalls: the result vector/mask registers are the output payload; a new op
//  may be accepted and worked on while rsp waits, but commits only once the
//  pending transaction is taken, so a stalled rsp never changes.
module masked_vector_integer_alu (
	input logic            clk,
	input logic            arst_n,
	mva_in_if.sink         req,
	mva_out_if.source      rsp
);
	localparam int ML = mva_pkg::MAX_LANES;
	localparam int L  = mva_pkg::LANES;

	// raw channel lanes
	mva_pkg::lane_t a_in [ML];
	mva_pkg::lane_t b_in [ML];

	assign a_in[0] = req.lane_a0;
	assign a_in[1] = req.lane_a1;
	assign a_in[2] = req.lane_a2;
	assign a_in[3] = req.lane_a3;
	assign b_in[0] = req.lane_b0;
	assign b_in[1] = req.lane_b1;
	assign b_in[2] = req.lane_b2;
	assign b_in[3] = req.lane_b3;

	// control
	mva_pkg::state_t             st_q, st_nx;
	logic [mva_pkg::CNT_W-1:0]   cnt_q;
	logic                        out_vld_q;
	logic                        accept, is_div, slot_free, commit;

	// held operands
	mva_pkg::func_t              func_q;
	logic [mva_pkg::MASK_W-1:0]  em_q, om_q;
	mva_pkg::lane_t              a_q [ML];
	mva_pkg::lane_t              b_q [ML];

	// architectural state, also the output payload
	mva_pkg::lane_t              vec_q [ML];
	logic [mva_pkg::MASK_W-1:0]  msk_q;
	mva_pkg::lane_t              scalar_q;

	mva_pkg::lane_ctl_t          ctl;
	mva_pkg::lane_out_t          lane_o [ML];
	mva_pkg::lane_t              vec_nx [ML];
	logic [mva_pkg::MASK_W-1:0]  msk_nx;
	mva_pkg::lane_t              scalar_nx;

	assign is_div    = (mva_pkg::func_t'(req.func) == mva_pkg::F_DIV);
	assign accept    = req.valid && req.ready;
	assign slot_free = !out_vld_q || rsp.ready;

	always_comb begin
		st_nx     = st_q;
		req.ready = 1'b0;
		commit    = 1'b0;
		case (st_q)
			mva_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid)
					st_nx = is_div ? mva_pkg::ST_DIV : mva_pkg::ST_COMMIT;
			end
			mva_pkg::ST_DIV: begin
				if (cnt_q == '0)
					st_nx = mva_pkg::ST_COMMIT;
			end
			mva_pkg::ST_COMMIT: begin
				if (slot_free) begin
					commit = 1'b1;
					st_nx  = mva_pkg::ST_IDLE;
				end
			end
			default: st_nx = mva_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= mva_pkg::ST_IDLE;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (accept)
				cnt_q <= mva_pkg::CNT_W'(mva_pkg::LANE_BITS - 1);
			else if (st_q == mva_pkg::ST_DIV)
				cnt_q <= cnt_q - 1'b1;
			if (commit)
				out_vld_q <= 1'b1;
			else if (rsp.ready)
				out_vld_q <= 1'b0;
		end
	end

	// operand capture; masks drop lanes beyond LANES
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= mva_pkg::func_t'(req.func);
			em_q   <= req.exec_mask & mva_pkg::LANE_MASK;
			om_q   <= req.other_mask & mva_pkg::LANE_MASK;
			a_q    <= a_in;
			b_q    <= b_in;
		end
	end

	// result state updates only when the previous transaction is gone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ML; i++)
				vec_q[i] <= '0;
			msk_q    <= '0;
			scalar_q <= '0;
		end else if (commit) begin
			vec_q    <= vec_nx;
			msk_q    <= msk_nx;
			scalar_q <= scalar_nx;
		end
	end

	assign ctl.func     = func_q;
	assign ctl.div_load = accept && is_div;
	assign ctl.div_step = (st_q == mva_pkg::ST_DIV);

	for (genvar g = 0; g < ML; g++) begin : g_lane
		if (g < L) begin : g_act
			mva_lane u_lane (
				.clk      (clk),
				.ctl      (ctl),
				.en       (em_q[g]),
				.a_in     (a_in[g]),
				.b_in     (b_in[g]),
				.a        (a_q[g]),
				.b        (b_q[g]),
				.bcast    (b_q[0]),
				.old_val  (vec_q[g]),
				.old_mbit (msk_q[g]),
				.res      (lane_o[g])
			);
		end else begin : g_off
			assign lane_o[g] = '0;   // unused lanes stay zero
		end
	end

	mva_merge u_merge (
		.func      (func_q),
		.em        (em_q),
		.om        (om_q),
		.a         (a_q),
		.lane_o    (lane_o),
		.vec_nx    (vec_nx),
		.msk_nx    (msk_nx),
		.scalar_nx (scalar_nx)
	);

	assign rsp.valid      = out_vld_q;
	assign rsp.res_0      = vec_q[0];
	assign rsp.res_1      = vec_q[1];
	assign rsp.res_2      = vec_q[2];
	assign rsp.res_3      = vec_q[3];
	assign rsp.mask_out   = msk_q;
	assign rsp.scalar_out = scalar_q;

	// a div transaction goes through the divider, never straight to commit
	a_div_path: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_div |=> st_q == mva_pkg::ST_DIV)
		else $error("div op skipped the divider");

	// state held while the pending result has not been taken
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> $stable(msk_q) && $stable(scalar_q))
		else $error("result state changed under a stalled transaction");

	// a new result only appears out of the commit state
	a_vld_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(st_q == mva_pkg::ST_COMMIT))
		else $error("result valid raised outside commit");

	// divider does not leave before its count expires
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == mva_pkg::ST_DIV && cnt_q != '0 |=> st_q == mva_pkg::ST_DIV)
		else $error("divider left early");
endmodule

/* sv/mva_lane.sv */
// One lane of the vector ALU: lane-wise ops, compares and a bit-serial divider.
// Depends on mva_pkg.
module mva_lane (
	input  logic                  clk,
	input  mva_pkg::lane_ctl_t    ctl,
	input  logic                  en,
	input  mva_pkg::lane_t        a_in,     // raw operands, sampled on div_load
	input  mva_pkg::lane_t        b_in,
	input  mva_pkg::lane_t        a,        // held operands
	input  mva_pkg::lane_t        b,
	input  mva_pkg::lane_t        bcast,
	input  mva_pkg::lane_t        old_val,
	input  logic                  old_mbit,
	output mva_pkg::lane_out_t    res
);
	localparam int W = mva_pkg::LANE_BITS;
	localparam logic [mva_pkg::SHAMT_W-1:0] SH_MAX =
		(W - 1 > 31) ? mva_pkg::SHAMT_W'(31) : mva_pkg::SHAMT_W'(W - 1);

	// restoring divider on magnitudes, one quotient bit per step
	mva_pkg::lane_t rem_q, quo_q, dvs_q;
	logic [W:0]     sh;
	logic [W+1:0]   diff;
	logic           fits;

	assign sh   = {rem_q, quo_q[W-1]};
	assign diff = {1'b0, sh} - {2'b00, dvs_q};
	assign fits = !diff[W+1];

	always_ff @(posedge clk) begin
		if (ctl.div_load) begin
			rem_q <= '0;
			quo_q <= mva_pkg::lane_abs(a_in);
			dvs_q <= mva_pkg::lane_abs(b_in);
		end else if (ctl.div_step) begin
			rem_q <= fits ? diff[W-1:0] : sh[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	mva_pkg::lane_t               prod, quot, sra;
	logic [mva_pkg::SHAMT_W-1:0]  amt;

	assign prod = a * b;
	always_comb begin
		if (b == '0)
			quot = '1;
		else if (a[W-1] ^ b[W-1])
			quot = mva_pkg::lane_t'(-quo_q);
		else
			quot = quo_q;
	end
	assign amt = (b[mva_pkg::SHAMT_W-1:0] > SH_MAX) ? SH_MAX : b[mva_pkg::SHAMT_W-1:0];
	assign sra = mva_pkg::lane_t'($signed(a) >>> amt);

	always_comb begin
		res.val  = old_val;
		res.mbit = old_mbit;
		if (en) begin
			case (ctl.func)
				mva_pkg::F_ADD:  res.val  = a + b;
				mva_pkg::F_SUB:  res.val  = a - b;
				mva_pkg::F_MUL:  res.val  = prod;
				mva_pkg::F_DIV:  res.val  = quot;
				mva_pkg::F_ABS:  res.val  = mva_pkg::lane_abs(a);
				mva_pkg::F_SRA:  res.val  = sra;
				mva_pkg::F_AND:  res.val  = a & b;
				mva_pkg::F_GT:   res.mbit = $signed(a) > $signed(b);
				mva_pkg::F_LT:   res.mbit = $signed(a) < $signed(b);
				mva_pkg::F_EQ:   res.mbit = (a == b);
				mva_pkg::F_SET:  res.val  = bcast;
				mva_pkg::F_MOVE: res.val  = a;
				default: ;
			endcase
		end
	end
endmodule

/* sv/mva_merge.sv */
// Merge stage: cross-lane ops (hadd, interleave), mask ops and scalar results.
// Depends on mva_pkg.
module mva_merge (
	input  mva_pkg::func_t                func,
	input  logic [mva_pkg::MASK_W-1:0]    em,
	input  logic [mva_pkg::MASK_W-1:0]    om,
	input  mva_pkg::lane_t                a      [mva_pkg::MAX_LANES],
	input  mva_pkg::lane_out_t            lane_o [mva_pkg::MAX_LANES],
	output mva_pkg::lane_t                vec_nx [mva_pkg::MAX_LANES],
	output logic [mva_pkg::MASK_W-1:0]    msk_nx,
	output mva_pkg::lane_t                scalar_nx
);
	localparam int L = mva_pkg::LANES;

	for (genvar g = 0; g < mva_pkg::MAX_LANES; g++) begin : g_vec
		localparam int  HP      = g - (g % 2);
		localparam bit  HADD_OK = (g < L) && (HP + 1 < L);
		localparam int  HB      = HADD_OK ? HP + 1 : HP;
		localparam int  SRC     = (g < L / 2) ? 2 * g : 2 * (g - L / 2) + 1;
		localparam bit  ILV_OK  = (g < L) && (SRC < L);
		localparam int  IS      = ILV_OK ? SRC : 0;

		always_comb begin
			vec_nx[g] = lane_o[g].val;
			if (HADD_OK && func == mva_pkg::F_HADD)
				vec_nx[g] = a[HP] + a[HB];
			else if (ILV_OK && func == mva_pkg::F_ILV)
				vec_nx[g] = a[IS];
		end
	end

	always_comb begin
		msk_nx = '0;
		for (int i = 0; i < L; i++)
			msk_nx[i] = lane_o[i].mbit;
		case (func)
			mva_pkg::F_NOT:  msk_nx = ~em & mva_pkg::LANE_MASK;
			mva_pkg::F_OR:   msk_nx = em | om;
			mva_pkg::F_MAND: msk_nx = em & om;
			default: ;
		endcase
	end

	mva_pkg::lane_t sum, first;

	always_comb begin
		sum = '0;
		for (int i = 0; i < L; i++)
			if (em[i])
				sum = sum + a[i];
	end

	always_comb begin
		first = '0;
		for (int i = L - 1; i >= 0; i--)
			if (em[i])
				first = mva_pkg::lane_t'(i);
	end

	always_comb begin
		case (func)
			mva_pkg::F_REDUCE: scalar_nx = sum;
			mva_pkg::F_COUNT:  scalar_nx = mva_pkg::lane_t'($countones(em));
			mva_pkg::F_FIRST:  scalar_nx = first;
			default:           scalar_nx = '0;
		endcase
	end
endmodule
